// File: hw/rtl/s256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hash unit.
`default_nettype none
package s256_pkg;

    localparam int MSG_WORDS = 24;                        // words per message, 16..29
    localparam int CNT_W     = 5;                         // front word counter width
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MSG_WORDS - 1);
    localparam logic [CNT_W-1:0] BLK_IDX  = CNT_W'(15);
    localparam logic [3:0]  PAD_POS  = 4'(MSG_WORDS - 16); // slot of the pad mark
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [31:0] LEN_WORD = 32'(MSG_WORDS * 32);

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [31:0] word;
        logic        end_block;  // closes the first 512-bit block
        logic        end_msg;    // last word of the message
    } item_t;

    typedef enum logic [2:0] {
        ST_LOAD1,
        ST_LOAD2,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha256_fixed_96_byte_hash_unit.sv
// Top level of the fixed-length SHA-256 hash unit.
// Usage:
//   Slave stream (s_): one 32-bit big-endian message word per beat, 24 beats
//   per message (96 bytes). No framing is needed; the unit counts words.
//   Master stream (m_): 8 digest words per message, word 0 first; m_tlast
//   marks the eighth word.
// Structure: a front end tags each word (end of first block, end of message)
//   and pushes it into a 4-entry queue; while loading a block the compression
//   core takes one queue word per cycle; it runs one SHA-256 round per cycle.
// Sequence per message: 16 words loaded, 64 rounds and a hash update for the
//   first block; the other 8 words, the padding words, 64 rounds and a hash
//   update for the second block; then 8 output beats. The round loop of the
//   core limits the message rate. The first digest word follows the padding,
//   the rounds and the hash update of the second block.
// The queue keeps taking words while the core computes or while a digest
//   waits, until it holds 4 words; then s_tready drops.
// A stalled receiver holds the digest word on m_tdata; the core waits.
// Reset (aresetn low, synchronous) empties the queue, clears the word count
//   and loads the standard initial hash values.
`default_nettype none
module sha256_fixed_96_byte_hash_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] message_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic             m_tlast    // last_word
);

    logic            push_valid, push_ready;
    s256_pkg::item_t push_item;
    logic            pop_valid, pop_ready;
    s256_pkg::item_t pop_item;

    s256_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    s256_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    s256_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// File: hw/rtl/s256_front.sv
// Input front end: counts message words and tags block and message ends.
`default_nettype none
module s256_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [31:0]     s_tdata,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output s256_pkg::item_t      push_item
);

    logic [s256_pkg::CNT_W-1:0] count_reg, count_next;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_item.word      = s_tdata;
        push_item.end_block = (count_reg == s256_pkg::BLK_IDX);
        push_item.end_msg   = (count_reg == s256_pkg::LAST_IDX);
        count_next = count_reg;
        if (s_tvalid && push_ready) begin
            count_next = push_item.end_msg ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/s256_queue.sv
// Short word queue between the front end and the compression core.
`default_nettype none
module s256_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire s256_pkg::item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output s256_pkg::item_t      pop_item
);

    s256_pkg::item_t             mem_reg [s256_pkg::QDEPTH];
    logic [s256_pkg::QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [s256_pkg::QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [s256_pkg::QAW:0]      fill_reg, fill_next;
    logic                        do_push, do_pop;

    always_comb begin
        push_ready  = (fill_reg != (s256_pkg::QAW+1)'(s256_pkg::QDEPTH));
        pop_valid   = (fill_reg != '0);
        pop_item    = mem_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/s256_core.sv
// Compression core: schedule window, one round per cycle, digest output.
`default_nettype none
module s256_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire s256_pkg::item_t pop_item,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast
);

    s256_pkg::state_t state_reg, state_next;
    logic [31:0] hash_reg  [8];
    logic [31:0] hash_next [8];
    logic [31:0] work_reg  [8];   // a..h
    logic [31:0] work_next [8];
    logic [31:0] sched_reg [16];  // W[t] .. W[t+15]
    logic [31:0] sched_next[16];
    logic [5:0]  round_reg, round_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  idx_reg, idx_next;
    logic        blk2_reg, blk2_next;
    logic        msgend_reg, msgend_next;

    logic        do_shift;
    logic [31:0] shift_in;
    logic [31:0] w_new, t1, t2;

    always_comb begin
        w_new = s256_pkg::ssig1(sched_reg[14]) + sched_reg[9]
              + s256_pkg::ssig0(sched_reg[1]) + sched_reg[0];
        t1 = work_reg[7] + s256_pkg::bsig1(work_reg[4])
           + (work_reg[6] ^ (work_reg[4] & (work_reg[5] ^ work_reg[6])))
           + s256_pkg::round_k(round_reg) + sched_reg[0];
        t2 = s256_pkg::bsig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[2] & (work_reg[0] ^ work_reg[1])));
    end

    always_comb begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        work_next   = work_reg;
        round_next  = round_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        blk2_next   = blk2_reg;
        msgend_next = msgend_reg;
        do_shift    = 1'b0;
        shift_in    = pop_item.word;
        pop_ready   = 1'b0;
        m_tvalid    = 1'b0;
        m_tdata     = hash_reg[idx_reg];
        m_tlast     = (idx_reg == 3'd7);

        case (state_reg)
            s256_pkg::ST_LOAD1: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    do_shift = 1'b1;
                    if (pop_item.end_msg) begin
                        msgend_next = 1'b1;
                    end
                    if (pop_item.end_block) begin
                        work_next  = hash_reg;
                        round_next = '0;
                        state_next = s256_pkg::ST_ROUND;
                    end
                end
            end
            s256_pkg::ST_LOAD2: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    do_shift = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (pop_item.end_msg) begin
                        state_next = s256_pkg::ST_PAD;
                    end
                end
            end
            s256_pkg::ST_PAD: begin
                do_shift = 1'b1;
                if (cnt_reg == s256_pkg::PAD_POS) begin
                    shift_in = s256_pkg::PAD_WORD;
                end else if (cnt_reg == 4'd15) begin
                    shift_in = s256_pkg::LEN_WORD;
                end else begin
                    shift_in = '0;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15) begin
                    blk2_next  = 1'b1;
                    work_next  = hash_reg;
                    round_next = '0;
                    state_next = s256_pkg::ST_ROUND;
                end
            end
            s256_pkg::ST_ROUND: begin
                do_shift     = 1'b1;
                shift_in     = w_new;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                round_next   = round_reg + 1'b1;
                if (round_reg == 6'd63) begin
                    state_next = s256_pkg::ST_FINAL;
                end
            end
            s256_pkg::ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                cnt_next = '0;
                idx_next = '0;
                if (blk2_reg) begin
                    state_next = s256_pkg::ST_OUT;
                end else if (msgend_reg) begin
                    // sixteen-word message: second block is padding only
                    cnt_next   = s256_pkg::PAD_POS;
                    state_next = s256_pkg::ST_PAD;
                end else begin
                    state_next = s256_pkg::ST_LOAD2;
                end
            end
            s256_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++) begin
                            hash_next[i] = s256_pkg::init_hash(3'(i));
                        end
                        blk2_next   = 1'b0;
                        msgend_next = 1'b0;
                        state_next  = s256_pkg::ST_LOAD1;
                    end
                end
            end
            default: begin
                state_next = s256_pkg::ST_LOAD1;
            end
        endcase

        for (int i = 0; i < 16; i++) begin
            sched_next[i] = sched_reg[i];
        end
        if (do_shift) begin
            for (int i = 0; i < 15; i++) begin
                sched_next[i] = sched_reg[i+1];
            end
            sched_next[15] = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        sched_reg <= sched_next;
        work_reg  <= work_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= s256_pkg::ST_LOAD1;
            round_reg  <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            blk2_reg   <= 1'b0;
            msgend_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= s256_pkg::init_hash(3'(i));
            end
        end else begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            blk2_reg   <= blk2_next;
            msgend_reg <= msgend_next;
            hash_reg   <= hash_next;
        end
    end

endmodule
`default_nettype wire
